/* rtl/core/gmc_pkg.sv */
package gmc_pkg;

    // controller states, one-hot
    typedef enum logic [5:0] {
        ST_STARTUP = 6'b000001,
        ST_STOP    = 6'b000010,
        ST_OPEN    = 6'b000100,
        ST_CLOSE   = 6'b001000,
        ST_ERROR   = 6'b010000,
        ST_SAFETY  = 6'b100000
    } t_state;

    // gate_mode codes seen on the result port
    localparam logic [2:0] MODE_STARTUP = 3'd0;
    localparam logic [2:0] MODE_STOP    = 3'd1;
    localparam logic [2:0] MODE_OPEN    = 3'd2;
    localparam logic [2:0] MODE_CLOSE   = 3'd3;
    localparam logic [2:0] MODE_ERROR   = 3'd4;
    localparam logic [2:0] MODE_SAFETY  = 3'd5;

    // bit positions in the led word
    localparam int LED_OPENED  = 0;
    localparam int LED_CLOSED  = 1;
    localparam int LED_BARRIER = 2;
    localparam int LED_ERROR   = 3;
    localparam int LED_FLASH   = 4;
    localparam int LED_SPARE   = 5;
    localparam int LED_MOPEN   = 6;
    localparam int LED_MCLOSE  = 7;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TICKS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS = 2'd1;

    localparam logic [7:0] ON_TICKS_RST     = 8'd4;
    localparam logic [7:0] PERIOD_TICKS_RST = 8'd5;

    typedef struct packed {
        logic btn_open;
        logic btn_close;
        logic btn_stop;
        logic limit_open;
        logic limit_closed;
        logic light_barrier;
    } t_sense;

    typedef struct packed {
        logic [7:0] on_ticks;
        logic [7:0] period_ticks;
    } t_cfg;

    function automatic logic [2:0] f_mode(input t_state s);
        logic [2:0] m;
        unique case (s)
            ST_STARTUP: m = MODE_STARTUP;
            ST_STOP:    m = MODE_STOP;
            ST_OPEN:    m = MODE_OPEN;
            ST_CLOSE:   m = MODE_CLOSE;
            ST_ERROR:   m = MODE_ERROR;
            ST_SAFETY:  m = MODE_SAFETY;
            default:    m = MODE_STARTUP;
        endcase
        return m;
    endfunction

endpackage

/* rtl/core/gmc_step.sv */
module gmc_step #(
    parameter int TIMER_BITS = 8
) (
    input  gmc_pkg::t_state         i_state,
    input  logic [7:0]              i_led,
    input  logic [2:0]              i_prev,
    input  logic [TIMER_BITS-1:0]   i_timer,
    input  gmc_pkg::t_sense         i_sense,
    input  gmc_pkg::t_cfg           i_cfg,
    output gmc_pkg::t_state         o_state,
    output logic [7:0]              o_led,
    output logic [2:0]              o_prev,
    output logic [TIMER_BITS-1:0]   o_timer
);
    import gmc_pkg::*;

    // compare width covers both the timer and the 8-bit registers
    localparam int CW = (TIMER_BITS > 8) ? TIMER_BITS : 8;
    localparam logic [CW-1:0] TMAX = CW'((32'd1 << TIMER_BITS) - 32'd1);

    logic [2:0]    w_btn;
    logic [2:0]    w_edge;
    logic          w_lo;
    logic          w_lc;
    logic          w_lb;
    logic          w_blink;
    t_state        w_s;
    logic [7:0]    w_led;
    logic [CW-1:0] w_t;
    logic [CW-1:0] w_on;
    logic [CW-1:0] w_per;

    always_comb begin
        w_btn   = {i_sense.btn_stop, i_sense.btn_close, i_sense.btn_open};
        w_edge  = w_btn & ~i_prev;
        w_lo    = i_sense.limit_open;
        w_lc    = i_sense.limit_closed;
        w_lb    = i_sense.light_barrier;
        w_s     = i_state;
        w_led   = i_led;
        w_blink = (i_state == ST_OPEN) || (i_state == ST_CLOSE);

        unique case (i_state)
            ST_STARTUP: begin
                w_led[LED_FLASH] = 1'b0;
                if (w_lc) w_s = ST_STOP;
            end
            ST_STOP: begin
                w_led[LED_FLASH]   = 1'b0;
                w_led[LED_MOPEN]   = 1'b0;
                w_led[LED_MCLOSE]  = 1'b0;
                w_led[LED_BARRIER] = 1'b0;
                w_led[LED_ERROR]   = 1'b0;
                if (w_edge[0]) w_s = ST_OPEN;
                if (w_edge[1]) w_s = ST_CLOSE;
                if (w_lo && w_lc) w_s = ST_ERROR;
            end
            ST_OPEN: begin
                w_led[LED_CLOSED]  = 1'b0;
                w_led[LED_BARRIER] = 1'b0;
                w_led[LED_MOPEN]   = 1'b1;
                if (w_lo && w_lc) w_s = ST_ERROR;
                if (w_edge[2]) w_s = ST_STOP;
                if (w_lo) begin
                    w_led[LED_OPENED] = 1'b1;
                    w_led[LED_MOPEN]  = 1'b0;
                    w_s = ST_STOP;
                end
            end
            ST_CLOSE: begin
                w_led[LED_MCLOSE]  = 1'b1;
                w_led[LED_OPENED]  = 1'b0;
                w_led[LED_BARRIER] = 1'b0;
                if (w_lo && w_lc) w_s = ST_ERROR;
                if (w_edge[2]) w_s = ST_STOP;
                if (w_lb) w_s = ST_SAFETY;
                if (w_lc) begin
                    w_s = ST_STOP;
                    w_led[LED_CLOSED] = 1'b1;
                end
            end
            ST_ERROR: begin
                w_s = (w_lo && w_lc) ? ST_ERROR : ST_STOP;
                w_led[LED_MOPEN]   = 1'b0;
                w_led[LED_MCLOSE]  = 1'b0;
                w_led[LED_BARRIER] = 1'b0;
                w_led[LED_OPENED]  = 1'b0;
                w_led[LED_CLOSED]  = 1'b0;
                w_led[LED_ERROR]   = 1'b1;
            end
            ST_SAFETY: begin
                w_led[LED_OPENED]  = 1'b0;
                w_led[LED_CLOSED]  = 1'b0;
                w_led[LED_ERROR]   = 1'b0;
                w_led[LED_FLASH]   = 1'b0;
                w_led[LED_MOPEN]   = 1'b0;
                w_led[LED_MCLOSE]  = 1'b0;
                w_led[LED_BARRIER] = 1'b1;
                if (w_edge[0]) w_s = ST_OPEN;
            end
            default: begin
            end
        endcase

        // warning light timer, enable taken from the state before the step
        w_t   = CW'(i_timer);
        w_on  = CW'(i_cfg.on_ticks);
        w_per = CW'(i_cfg.period_ticks);
        if (w_blink) begin
            if (w_t >= w_on) w_led[LED_FLASH] = 1'b0;
            if (w_t >= w_per) begin
                w_led[LED_FLASH] = 1'b1;
                w_t = '0;
            end
        end else begin
            w_t = (w_per > TMAX) ? TMAX : w_per;
        end
        // saturating increment
        if (w_t < TMAX) w_t = w_t + CW'(1);

        w_led[LED_SPARE] = 1'b0;
    end

    assign o_state = w_s;
    assign o_led   = w_led;
    assign o_prev  = w_btn;
    assign o_timer = w_t[TIMER_BITS-1:0];

endmodule

/* rtl/core/gate_motor_controller_unit.sv */
// Gate motor controller, stepped once per accepted tick request. One request can be
// accepted every clock cycle unless the input stalls; its result (led word and gate
// mode) is held in the output register from the next cycle on, in the single
// register stage behind the state and latch logic. The input stalls only while a
// result sits in the output register and the output side stalls. Configuration
// writes are always ready and take effect for the next tick.
module gate_motor_controller_unit #(
    parameter int TIMER_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tick request
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_btn_open,
    input  logic                            i_btn_close,
    input  logic                            i_btn_stop,
    input  logic                            i_limit_open,
    input  logic                            i_limit_closed,
    input  logic                            i_light_barrier,
    // result
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_led_word,
    output logic [2:0]                      o_gate_mode,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gmc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);
    import gmc_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [7:0]            r_led;
    logic [7:0]            n_led;
    logic [2:0]            r_prev;
    logic [2:0]            n_prev;
    logic [TIMER_BITS-1:0] r_timer;
    logic [TIMER_BITS-1:0] n_timer;
    logic                  r_out_valid;
    t_cfg                  r_cfg;
    t_sense                w_sense;
    logic                  w_in_acc;
    logic                  w_out_acc;

    assign o_stall     = r_out_valid && i_out_stall;
    assign w_in_acc    = i_valid && !o_stall;
    assign w_out_acc   = r_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign w_sense = '{
        btn_open:      i_btn_open,
        btn_close:     i_btn_close,
        btn_stop:      i_btn_stop,
        limit_open:    i_limit_open,
        limit_closed:  i_limit_closed,
        light_barrier: i_light_barrier
    };

    gmc_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_state (r_state),
        .i_led   (r_led),
        .i_prev  (r_prev),
        .i_timer (r_timer),
        .i_sense (w_sense),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_led   (n_led),
        .o_prev  (n_prev),
        .o_timer (n_timer)
    );

    // the state latches double as the result register: they only move on accept,
    // and accept waits until the previous result has left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_STARTUP;
            r_led       <= '0;
            r_prev      <= '0;
            r_timer     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_state <= n_state;
                r_led   <= n_led;
                r_prev  <= n_prev;
                r_timer <= n_timer;
            end
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_ticks     <= ON_TICKS_RST;
            r_cfg.period_ticks <= PERIOD_TICKS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ON_TICKS:     r_cfg.on_ticks     <= i_cfg_data;
                CFG_PERIOD_TICKS: r_cfg.period_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_word  = r_led;
    assign o_gate_mode = f_mode(r_state);

    a_motor_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_led_word[LED_MOPEN] && o_led_word[LED_MCLOSE]))
        else $error("motor open and close driven together");

    a_acc_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_out_valid)
        else $error("accepted request produced no result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> ($stable(o_led_word) && $stable(o_gate_mode)))
        else $error("result changed without a request");

    a_open_no_mclose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_gate_mode == MODE_OPEN) |-> !o_led_word[LED_MCLOSE])
        else $error("close motor on while opening");

endmodule

/* dv/tb.sv */
module tb;
    import gmc_pkg::*;

    localparam int TIMER_BITS = 8;
    localparam int TIMER_MAX  = (1 << TIMER_BITS) - 1;

    // indexes past the register file, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    typedef struct packed {
        logic [7:0] led;
        logic [2:0] mode;
    } t_gate_out;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_btn_open = 1'b0;
    logic       i_btn_close = 1'b0;
    logic       i_btn_stop = 1'b0;
    logic       i_limit_open = 1'b0;
    logic       i_limit_closed = 1'b0;
    logic       i_light_barrier = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_led_word;
    logic [2:0] o_gate_mode;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    gate_motor_controller_unit #(
        .TIMER_BITS(TIMER_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_btn_open     (i_btn_open),
        .i_btn_close    (i_btn_close),
        .i_btn_stop     (i_btn_stop),
        .i_limit_open   (i_limit_open),
        .i_limit_closed (i_limit_closed),
        .i_light_barrier(i_light_barrier),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_led_word     (o_led_word),
        .o_gate_mode    (o_gate_mode),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // gate model state
    logic [7:0] g_on_ticks = ON_TICKS_RST;
    logic [7:0] g_period_ticks = PERIOD_TICKS_RST;
    logic [2:0] g_mode = MODE_STARTUP;
    logic [2:0] g_prev_btn = '0;
    logic [7:0] g_leds = '0;
    int         g_timer = 0;

    t_sense    pending_ticks[$];
    t_gate_out expected_gate[$];
    int        queued_cnt = 0;
    int        err_cnt = 0;
    bit        tick_taken = 1'b0;
    bit        hold_off = 1'b0;
    bit        random_phase = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20 * 400000);
        $display("gate_motor_controller_unit: mismatch");
        $finish;
    end

    // one controller tick, mirrors the gate state machine and blink timer
    task automatic step_gate(input t_sense t);
        logic [2:0] btn;
        logic [2:0] rise;
        logic [2:0] m;
        logic [7:0] led;
        logic       blink;
        logic       both;
        btn   = {t.btn_stop, t.btn_close, t.btn_open};
        rise  = btn & ~g_prev_btn;
        m     = g_mode;
        led   = g_leds;
        both  = t.limit_open && t.limit_closed;
        blink = (m == MODE_OPEN) || (m == MODE_CLOSE);
        g_prev_btn = btn;
        case (m)
            MODE_STARTUP: begin
                led[LED_FLASH] = 1'b0;
                if (t.limit_closed) m = MODE_STOP;
            end
            MODE_STOP: begin
                led[LED_FLASH]   = 1'b0;
                led[LED_MOPEN]   = 1'b0;
                led[LED_MCLOSE]  = 1'b0;
                led[LED_BARRIER] = 1'b0;
                led[LED_ERROR]   = 1'b0;
                if (rise[0]) m = MODE_OPEN;
                if (rise[1]) m = MODE_CLOSE;
                if (both) m = MODE_ERROR;
            end
            MODE_OPEN: begin
                led[LED_CLOSED]  = 1'b0;
                led[LED_BARRIER] = 1'b0;
                led[LED_MOPEN]   = 1'b1;
                if (both) m = MODE_ERROR;
                if (rise[2]) m = MODE_STOP;
                if (t.limit_open) begin
                    led[LED_OPENED] = 1'b1;
                    led[LED_MOPEN]  = 1'b0;
                    m = MODE_STOP;
                end
            end
            MODE_CLOSE: begin
                led[LED_MCLOSE]  = 1'b1;
                led[LED_OPENED]  = 1'b0;
                led[LED_BARRIER] = 1'b0;
                if (both) m = MODE_ERROR;
                if (rise[2]) m = MODE_STOP;
                if (t.light_barrier) m = MODE_SAFETY;
                if (t.limit_closed) begin
                    m = MODE_STOP;
                    led[LED_CLOSED] = 1'b1;
                end
            end
            MODE_ERROR: begin
                m = both ? MODE_ERROR : MODE_STOP;
                led[LED_MOPEN]   = 1'b0;
                led[LED_MCLOSE]  = 1'b0;
                led[LED_BARRIER] = 1'b0;
                led[LED_OPENED]  = 1'b0;
                led[LED_CLOSED]  = 1'b0;
                led[LED_ERROR]   = 1'b1;
            end
            MODE_SAFETY: begin
                led[LED_OPENED]  = 1'b0;
                led[LED_CLOSED]  = 1'b0;
                led[LED_ERROR]   = 1'b0;
                led[LED_FLASH]   = 1'b0;
                led[LED_MOPEN]   = 1'b0;
                led[LED_MCLOSE]  = 1'b0;
                led[LED_BARRIER] = 1'b1;
                if (rise[0]) m = MODE_OPEN;
            end
            default: ;
        endcase
        // blink enable comes from the state before this tick
        if (blink) begin
            if (g_timer >= g_on_ticks) led[LED_FLASH] = 1'b0;
            if (g_timer >= g_period_ticks) begin
                led[LED_FLASH] = 1'b1;
                g_timer = 0;
            end
        end else begin
            g_timer = (g_period_ticks > TIMER_MAX) ? TIMER_MAX : g_period_ticks;
        end
        if (g_timer < TIMER_MAX) g_timer++;
        led[LED_SPARE] = 1'b0;
        g_mode = m;
        g_leds = led;
        expected_gate.push_back('{led: led, mode: m});
    endtask

    task automatic flag_error(input string what, input int want, input int got);
        err_cnt++;
        if (err_cnt <= 10) $display("error: %s expected 0x%0h got 0x%0h", what, want, got);
    endtask

    // input acceptance and result checking
    always @(posedge i_clk) begin
        t_gate_out want;
        tick_taken = i_rst_n && i_valid && !o_stall;
        if (tick_taken) begin
            step_gate({i_btn_open, i_btn_close, i_btn_stop,
                       i_limit_open, i_limit_closed, i_light_barrier});
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_gate.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) begin
                    $display("error: result with no request outstanding, led 0x%0h mode %0d",
                             o_led_word, o_gate_mode);
                end
            end else begin
                want = expected_gate.pop_front();
                if (want.led != o_led_word) flag_error("led word", want.led, o_led_word);
                if (want.mode != o_gate_mode) flag_error("gate mode", want.mode, o_gate_mode);
            end
        end
    end

    // request driver: bursts with random gaps, no gaps during the hold-off
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge i_clk) begin
        t_sense t;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || tick_taken) begin
            if (gap_left > 0 && !hold_off) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                t = pending_ticks.pop_front();
                i_btn_open      <= t.btn_open;
                i_btn_close     <= t.btn_close;
                i_btn_stop      <= t.btn_stop;
                i_limit_open    <= t.limit_open;
                i_limit_closed  <= t.limit_closed;
                i_light_barrier <= t.light_barrier;
                i_valid         <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                gap_left = 0;
                i_valid <= 1'b0;
            end
        end
    end

    // result side stall pattern, the mode is redrawn whenever its countdown runs out
    int stall_mode = 0;
    int stall_left = 0;
    int rx_phase = 0;

    always @(negedge i_clk) begin
        bit s;
        rx_phase++;
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 80);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: s = 1'b0;
            1: s = ($urandom_range(0, 3) == 0);
            2: s = ($urandom_range(0, 3) != 0);
            default: s = (rx_phase % 3 == 0);
        endcase
        i_out_stall <= hold_off || s;
    end

    // long hold-off on the result side so the input backs up
    initial begin
        wait (random_phase);
        repeat (100) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (50) @(posedge i_clk);
        hold_off = 1'b0;
    end

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic push_tick(input bit bo, input bit bc, input bit bs,
                             input bit lo, input bit lc, input bit lb);
        t_sense t;
        t.btn_open      = bo;
        t.btn_close     = bc;
        t.btn_stop      = bs;
        t.limit_open    = lo;
        t.limit_closed  = lc;
        t.light_barrier = lb;
        pending_ticks.push_back(t);
        queued_cnt++;
    endtask

    task automatic push_quiet();
        push_tick(chance(6), chance(6), chance(6), chance(3), chance(3), chance(4));
    endtask

    task automatic push_zeros(input int n);
        repeat (n) push_tick(0, 0, 0, 0, 0, 0);
    endtask

    // open from stop, run n ticks with the warning light, then stop
    task automatic blink_run(input int n);
        push_zeros(1);
        push_tick(1, 0, 0, 0, 0, 0);
        push_zeros(n);
        push_tick(0, 0, 1, 0, 0, 0);
        push_zeros(1);
    endtask

    // one well-formed gate sequence with random content, or a little noise
    task automatic add_scenario();
        int n;
        int k;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
        k = $urandom_range(1, 3);
        push_tick(0, 0, 0, 0, 0, chance(10));
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                repeat (k) push_tick(1, 0, chance(10), 0, 0, chance(10));
                repeat (n) push_quiet();
                case ($urandom_range(0, 3))
                    0, 1: repeat (k) push_tick(0, 0, 0, 1, 0, chance(20));
                    2: push_tick(0, chance(20), 1, 0, 0, 0);
                    default: push_tick(0, 0, chance(50), 1, 1, 0);
                endcase
            end
            3, 4, 5: begin
                repeat (k) push_tick(chance(10), 1, chance(10), 0, 0, 0);
                repeat (n) push_quiet();
                case ($urandom_range(0, 4))
                    0, 1: repeat (k) push_tick(0, 0, 0, chance(10), 1, chance(30));
                    2: begin
                        // barrier trips, then reopen out of the safety stop
                        repeat (k) push_tick(0, 0, chance(20), 0, 0, 1);
                        repeat ($urandom_range(0, 3)) push_quiet();
                        push_zeros(1);
                        push_tick(1, chance(20), 0, 0, 0, chance(50));
                    end
                    3: push_tick(0, 0, 1, 0, chance(20), chance(20));
                    default: push_tick(0, 0, 0, 1, 1, chance(50));
                endcase
            end
            6: begin
                // both limits at once, sensor fault
                repeat (k) push_tick(chance(30), chance(30), chance(30), 1, 1, chance(30));
                push_tick(0, 0, 0, chance(50), 0, 0);
            end
            7: push_tick(chance(20), chance(20), 1, chance(10), chance(10), chance(10));
            default: begin
                repeat (k) begin
                    push_tick(chance(50), chance(50), chance(50),
                              chance(50), chance(50), chance(50));
                end
            end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_ON_TICKS) g_on_ticks = val;
        else if (idx == CFG_PERIOD_TICKS) g_period_ticks = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_blink(input logic [7:0] on_val, input logic [7:0] period_val);
        write_reg(CFG_ON_TICKS, on_val);
        write_reg(CFG_PERIOD_TICKS, period_val);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || i_valid || expected_gate.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    initial begin
        int target;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk through every state at reset blink settings
        push_tick(0, 0, 0, 0, 0, 0);
        push_tick(0, 0, 0, 1, 0, 0);    // startup ignores the open limit
        push_tick(1, 1, 1, 1, 1, 1);    // closed limit leaves startup
        push_tick(0, 0, 0, 0, 0, 0);
        push_tick(1, 0, 0, 0, 0, 0);    // opening
        push_zeros(6);
        push_tick(0, 0, 1, 0, 0, 0);    // stop press
        push_tick(0, 0, 1, 0, 0, 0);    // held stop is not a new press
        push_tick(0, 1, 0, 0, 0, 0);    // closing
        push_tick(0, 1, 1, 0, 0, 0);    // stop while close still held
        push_tick(0, 0, 0, 0, 0, 0);
        push_tick(0, 1, 0, 0, 0, 0);
        push_zeros(2);
        push_tick(0, 0, 0, 0, 0, 1);    // barrier -> safety stop
        push_tick(1, 0, 0, 0, 0, 1);    // open press leaves safety stop
        push_tick(0, 0, 0, 1, 0, 0);    // open limit
        push_tick(0, 1, 0, 0, 0, 0);
        push_tick(0, 0, 1, 0, 1, 1);    // closed limit wins over stop and barrier
        push_tick(0, 0, 0, 1, 1, 0);    // both limits -> sensor error
        push_tick(0, 0, 0, 1, 1, 0);
        push_tick(0, 0, 0, 0, 0, 0);
        push_tick(1, 1, 0, 0, 0, 0);    // close press wins over open press
        push_tick(0, 0, 0, 1, 1, 0);
        wait_idle();

        set_blink(8'd1, 8'd1);
        blink_run(6);
        wait_idle();
        set_blink(8'd254, 8'd1);        // on time above the period
        blink_run(6);
        wait_idle();
        set_blink(8'd1, 8'd254);
        blink_run(260);
        wait_idle();
        set_blink(8'd255, 8'd255);      // timer saturates at full scale
        blink_run(270);
        wait_idle();
        write_reg(CFG_IDX_SPARE_A, 8'($urandom));
        write_reg(CFG_IDX_SPARE_B, 8'($urandom));
        set_blink(8'd0, 8'd0);          // zero period relights every tick
        blink_run(4);
        wait_idle();
        set_blink(8'd10, 8'd3);
        blink_run(8);
        wait_idle();

        random_phase = 1'b1;
        repeat (4) begin
            if ($urandom_range(0, 1) == 0) begin
                set_blink(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)));
            end else begin
                set_blink(8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)));
            end
            target = queued_cnt + 110;
            while (queued_cnt < target) add_scenario();
            wait_idle();
        end

        if (err_cnt == 0) begin
            $display("gate_motor_controller_unit: match");
        end else begin
            $display("gate_motor_controller_unit: mismatch");
        end
        $finish;
    end

endmodule
